/* hw/rtl/rwib_pkg.sv */
// Shared types, codes and fixed widths for the RAID write-intent bitmap unit.
package rwib_pkg;

    localparam int FUNC_W     = 3;
    localparam int SID_W      = 12;
    localparam int WIDX_W     = 7;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 16;
    localparam int SCNT_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_PERIOD  = 2'd2;

    localparam logic [SCNT_W-1:0] STRIPE_COUNT_RST = 13'd4096;
    localparam logic [CNT_W-1:0]  COPY_PERIOD_RST  = 16'd100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOG        = 3'd0,
        FUNC_UNLOG      = 3'd1,
        FUNC_CHECKPOINT = 3'd2,
        FUNC_FIND       = 3'd3,
        FUNC_READ       = 3'd4,
        FUNC_WRITE      = 3'd5
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PREP,
        ST_UPDATE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic prep;
        logic update;
        logic rd_walk;
        logic copy_wr;
        logic walk_inc;
        logic scan_chk;
        logic out_load;
        logic mod_start;
        logic mod_step;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              sid_ok;
        logic              walk_last;
        logic              copy_hit;
        logic              scan_hit;
        logic              scan_last;
        logic              mod_last;
        logic              period_wr;
    } dp_stat_t;

endpackage

/* hw/rtl/rwib_ctrl.sv */
// Sequencing state machine for the write-intent bitmap unit.
module rwib_ctrl
    import rwib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dp_cmd_t               cmd,
    input  dp_stat_t              stat
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.walk_inc = 1'b1;
                if (stat.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = !stat.period_wr;
                if (stat.period_wr) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end else if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_func) inside
                        FUNC_CHECKPOINT: begin
                            state_next = ST_COPY_RD;
                        end
                        FUNC_LOG, FUNC_UNLOG, FUNC_FIND, FUNC_READ, FUNC_WRITE: begin
                            state_next = ST_PREP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (stat.period_wr) begin
                    cmd.mod_start = 1'b1;
                end else begin
                    cmd.mod_step = 1'b1;
                    if (stat.mod_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                if (stat.func == FUNC_FIND) begin
                    state_next = stat.sid_ok ? ST_SCAN_RD : ST_DONE;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = stat.copy_hit ? ST_COPY_RD : ST_DONE;
            end
            ST_COPY_RD: begin
                cmd.rd_walk = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd.copy_wr = 1'b1;
                if (stat.walk_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_inc = 1'b1;
                    state_next   = ST_COPY_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd.rd_walk = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (stat.scan_hit || stat.scan_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_inc = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/rwib_datapath.sv */
// Bitmap memories, configuration registers, entry counter and result registers.
module rwib_datapath
    import rwib_pkg::*;
#(
    parameter int MAX_STRIPES = 4096,
    parameter int WORD_BITS   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [SID_W-1:0]      s_stripe_id,
    input  logic [WIDX_W-1:0]     s_word_index,
    input  logic [DATA_W-1:0]     s_word_data,
    output logic                  m_flush_request,
    output logic                  m_found,
    output logic [SID_W-1:0]      m_found_stripe,
    output logic [DATA_W-1:0]     m_read_word
);

    localparam int NWORDS  = (MAX_STRIPES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BPW     = $clog2(WORD_BITS);
    localparam int SPAN_W  = $clog2(NWORDS * WORD_BITS + WORD_BITS + 1);
    localparam int CW      = (SPAN_W > SCNT_W) ? SPAN_W : SCNT_W;
    localparam int DIV_SH  = 20;
    localparam int RECIP   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W  = 30;
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    logic                  log_enable_reg;
    logic [SCNT_W-1:0]     stripe_count_reg;
    logic [CNT_W-1:0]      copy_period_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [SID_W-1:0]      sid_reg;
    logic [WIDX_W-1:0]     widx_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [AW-1:0]         q_reg;
    logic [BPW-1:0]        bitpos_reg;
    logic [CW-1:0]         base_reg;
    logic                  first_reg;
    logic [AW-1:0]         walk_reg;

    logic [WORD_BITS-1:0]  live_mem   [NWORDS];
    logic [WORD_BITS-1:0]  shadow_mem [NWORDS];
    logic [WORD_BITS-1:0]  live_rd_reg;
    logic [WORD_BITS-1:0]  shadow_rd_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      res_reg;
    logic [CNT_W-1:0]      div_src_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;

    logic                  flush_res_reg;
    logic                  found_res_reg;
    logic [SID_W-1:0]      fstripe_res_reg;
    logic [DATA_W-1:0]     rword_res_reg;
    logic                  m_flush_reg;
    logic                  m_found_reg;
    logic [SID_W-1:0]      m_fstripe_reg;
    logic [DATA_W-1:0]     m_rword_reg;

    logic [CW-1:0]         limit;
    logic                  sid_ok;
    logic                  widx_ok;
    logic                  is_word_op;
    logic [AW-1:0]         req_addr;
    logic [AW-1:0]         rd_addr;
    logic [PROD_W-1:0]     prod;
    logic [CW-1:0]         q_base;
    logic [WORD_BITS-1:0]  bit_mask;
    logic                  new_entry;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W:0]        res_inc;
    logic [CNT_W-1:0]      res_next;
    logic [WORD_BITS-1:0]  wdata_masked;
    logic [CW-1:0]         rem;
    logic [WORD_BITS-1:0]  keep;
    logic [WORD_BITS-1:0]  scan_bits;
    logic [BPW-1:0]        hit_pos;
    logic [CNT_W:0]        div_trial;
    logic [CNT_W-1:0]      div_rem;

    assign limit      = (CW'(stripe_count_reg) < CW'(MAX_STRIPES)) ?
                        CW'(stripe_count_reg) : CW'(MAX_STRIPES);
    assign sid_ok     = CW'(sid_reg) < limit;
    assign widx_ok    = 32'(widx_reg) < 32'(NWORDS);
    assign is_word_op = (func_reg == FUNC_READ) || (func_reg == FUNC_WRITE);
    assign req_addr   = is_word_op ? AW'(widx_reg) : q_reg;
    assign rd_addr    = cmd.rd_walk ? walk_reg : req_addr;
    assign prod       = PROD_W'(s_stripe_id) * PROD_W'(RECIP);
    assign q_base     = CW'(q_reg) * CW'(WORD_BITS);
    assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bitpos_reg;
    assign new_entry  = (func_reg == FUNC_LOG) && sid_ok &&
                        ((shadow_rd_reg & bit_mask) == '0);
    assign count_inc  = count_reg + 1'b1;
    assign res_inc    = {1'b0, res_reg} + 1'b1;
    assign res_next   = ((count_inc == '0) || (res_inc == {1'b0, copy_period_reg})) ?
                        '0 : res_inc[CNT_W-1:0];
    assign wdata_masked = WORD_BITS'(wdata_reg);

    assign rem = limit - base_reg;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            keep[j] = (!first_reg || (BPW'(j) >= bitpos_reg)) && (CW'(j) < rem);
        end
    end

    assign scan_bits = shadow_rd_reg & keep;

    always_comb begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (scan_bits[j]) begin
                hit_pos = BPW'(j);
            end
        end
    end

    assign div_trial = {res_reg, div_src_reg[CNT_W-1]};
    assign div_rem   = (div_trial >= {1'b0, copy_period_reg}) ?
                       CNT_W'(div_trial - {1'b0, copy_period_reg}) : div_trial[CNT_W-1:0];

    always_comb begin
        stat           = '0;
        stat.func      = func_reg;
        stat.sid_ok    = sid_ok;
        stat.walk_last = walk_reg == LAST_WORD;
        stat.copy_hit  = new_entry && (copy_period_reg != '0) && (res_next == '0);
        stat.scan_hit  = |scan_bits;
        stat.scan_last = (base_reg + CW'(WORD_BITS)) >= limit;
        stat.mod_last  = div_cnt_reg == '0;
        stat.period_wr = cfg_wr_en && (cfg_index == CFG_COPY_PERIOD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_enable_reg   <= 1'b0;
            stripe_count_reg <= STRIPE_COUNT_RST;
            copy_period_reg  <= COPY_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOG_ENABLE:   log_enable_reg   <= cfg_wr_data[0];
                CFG_STRIPE_COUNT: stripe_count_reg <= cfg_wr_data[SCNT_W-1:0];
                CFG_COPY_PERIOD:  copy_period_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
        end else if (cmd.load || cmd.update) begin
            walk_reg <= '0;
        end else if (cmd.prep) begin
            walk_reg <= q_reg;
        end else if (cmd.walk_inc) begin
            walk_reg <= walk_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            sid_reg   <= s_stripe_id;
            widx_reg  <= s_word_index;
            wdata_reg <= s_word_data;
            q_reg     <= AW'(prod >> DIV_SH);
        end
        if (cmd.prep) begin
            bitpos_reg <= BPW'(CW'(sid_reg) - q_base);
            base_reg   <= q_base;
            first_reg  <= 1'b1;
        end else if (cmd.walk_inc) begin
            base_reg   <= base_reg + CW'(WORD_BITS);
            first_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            live_mem[walk_reg]   <= '0;
            shadow_mem[walk_reg] <= '0;
        end else begin
            if (cmd.update && sid_ok) begin
                if (func_reg == FUNC_LOG) begin
                    live_mem[req_addr] <= live_rd_reg | bit_mask;
                end else if (func_reg == FUNC_UNLOG) begin
                    live_mem[req_addr] <= live_rd_reg & ~bit_mask;
                end
            end
            if (cmd.update && new_entry) begin
                shadow_mem[req_addr] <= shadow_rd_reg | bit_mask;
            end else if (cmd.update && (func_reg == FUNC_WRITE) && widx_ok) begin
                shadow_mem[req_addr] <= wdata_masked;
            end else if (cmd.copy_wr) begin
                shadow_mem[walk_reg] <= live_rd_reg;
            end
        end
        live_rd_reg   <= live_mem[rd_addr];
        shadow_rd_reg <= shadow_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            res_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.update && new_entry) begin
            count_reg <= count_inc;
            res_reg   <= res_next;
        end else if (cmd.mod_start) begin
            res_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(CNT_W - 1);
        end else if (cmd.mod_step) begin
            res_reg     <= div_rem;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            div_src_reg <= count_reg;
        end else if (cmd.mod_step) begin
            div_src_reg <= {div_src_reg[CNT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            flush_res_reg   <= 1'b0;
            found_res_reg   <= 1'b0;
            fstripe_res_reg <= '0;
            rword_res_reg   <= '0;
        end else begin
            if (cmd.update) begin
                flush_res_reg <= new_entry && log_enable_reg;
                if ((func_reg == FUNC_READ) && widx_ok) begin
                    rword_res_reg <= DATA_W'(shadow_rd_reg);
                end
            end
            if (cmd.scan_chk && stat.scan_hit) begin
                found_res_reg   <= 1'b1;
                fstripe_res_reg <= SID_W'(base_reg + CW'(hit_pos));
            end
        end
        if (cmd.out_load) begin
            m_flush_reg   <= flush_res_reg;
            m_found_reg   <= found_res_reg;
            m_fstripe_reg <= fstripe_res_reg;
            m_rword_reg   <= rword_res_reg;
        end
    end

    assign m_flush_request = m_flush_reg;
    assign m_found         = m_found_reg;
    assign m_found_stripe  = m_fstripe_reg;
    assign m_read_word     = m_rword_reg;

endmodule

/* hw/rtl/raid_write_intent_bitmap_unit.sv */
// RAID write-intent bitmap unit: top level joining controller and datapath.
//
// Requests enter on s_valid/s_ready and results leave on m_valid/m_ready, one result per
// request, in order. Registers must be written through cfg_wr_en/cfg_index/cfg_wr_data
// by the user only while the unit is idle; the unit itself does not enforce this.
// With W = ceil(MAX_STRIPES / WORD_BITS) map words:
//   log, unlog, read word, write word: prepare, then update the addressed map word.
//   checkpoint, or a log reaching the copy period: copy all W live words to shadow.
//   find next dirty: scan shadow words from the stripe's word; unknown code: no work.
//   The next request is taken in ST_IDLE, which follows the result load in ST_DONE.
// Each shadow or live word goes through the single memory read port; during copies and
// scans a word is read, then written or checked, before the next is read. A copy_period
// write starts a remainder recompute of the entry counter during which s_ready is low.
// After reset a clearing pass zeroes both maps; s_ready stays low meanwhile,
// configuration writes are taken. A result held by a stalled receiver stays in the
// output register; the unit still takes the next request and keeps its result until the
// output register frees.
module raid_write_intent_bitmap_unit
    import rwib_pkg::*;
#(
    parameter int MAX_STRIPES = 4096,
    parameter int WORD_BITS   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [SID_W-1:0]      s_stripe_id,
    input  logic [WIDX_W-1:0]     s_word_index,
    input  logic [DATA_W-1:0]     s_word_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_flush_request,
    output logic                  m_found,
    output logic [SID_W-1:0]      m_found_stripe,
    output logic [DATA_W-1:0]     m_read_word
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rwib_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    rwib_datapath #(
        .MAX_STRIPES (MAX_STRIPES),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_func          (s_func),
        .s_stripe_id     (s_stripe_id),
        .s_word_index    (s_word_index),
        .s_word_data     (s_word_data),
        .m_flush_request (m_flush_request),
        .m_found         (m_found),
        .m_found_stripe  (m_found_stripe),
        .m_read_word     (m_read_word)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    a_found_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_flush_request && (m_read_word == '0))
        else $error("scan result carries fields of another request");

    a_flush_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flush_request |-> (m_found_stripe == '0) && (m_read_word == '0))
        else $error("flush result carries scan or read fields");

endmodule
